[rtl/gcdu_pkg.sv]
// constants and tables for the great circle distance pipeline
// no dependencies; imported by great_circle_distance_unit, its checker and the testbench
package gcdu_pkg;

  // port widths
  localparam int LAT_W  = 28;
  localparam int LON_W  = 29;
  localparam int RAD_W  = 20;
  localparam int DIST_W = 22;

  // cordic setup, angles are q30 radians
  localparam int CORDIC_STEPS = 31;
  localparam logic [31:0] CORDIC_GAIN = 32'h26DD3B6A;
  localparam logic [31:0] HALF_PI_Q30 = 32'h6487ED51;
  localparam logic [31:0] PI_Q30      = 32'hC90FDAA2;
  localparam logic [30:0] Q30_ONE     = 31'h4000_0000;

  // degree to radian scale, q32
  localparam logic [26:0] DEG2RAD_Q32 = 27'd74961321;

  localparam logic [RAD_W-1:0]  RADIUS_RESET = 20'd880657;
  localparam logic [DIST_W-1:0] DIST_MAX     = 22'd3294199;

  // arctangent of 2^-i in q30
  localparam logic [31:0] ATAN_Q30 [CORDIC_STEPS] = '{
    32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76, 32'h01FFD55B,
    32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
    32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF, 32'h00003FFF, 32'h00001FFF,
    32'h00000FFF, 32'h000007FF, 32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F,
    32'h0000003F, 32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002,
    32'h00000001};

endpackage

[rtl/great_circle_distance_unit.sv]
// haversine great circle distance, fully pipelined
// depends on gcdu_pkg for constants and the arctangent table
//
//  channel   signals                                       direction
//  input     in_valid_i, in_stall_o, lat_a_i..lon_b_i      in
//  output    out_valid_o, out_stall_i, distance_out_o      out
//  config    cfg_valid_i, cfg_ready_o, earth_radius_i      in
//
// one position pair per cycle while in_stall_o is low; the path to the output register
// runs through the 31-step rotation cordic, the 31-step square root and the
// 31-step vectoring cordic in series, plus 13 stages of angle setup and products
// reset clears all valid bits and loads the default radius
// a stalled output parks one result in a skid register; the pipeline then
// freezes and the input stalls until the skid register drains
module great_circle_distance_unit import gcdu_pkg::*; #(
  parameter int ANGLE_FRAC_BITS = 20
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic signed [LAT_W-1:0]  lat_a_i,
  input  logic signed [LON_W-1:0]  lon_a_i,
  input  logic signed [LAT_W-1:0]  lat_b_i,
  input  logic signed [LON_W-1:0]  lon_b_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [DIST_W-1:0]        distance_out_o,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [RAD_W-1:0]         earth_radius_i
);

  localparam int F    = ANGLE_FRAC_BITS;
  localparam int PW   = F + 9;
  localparam int UW   = 34;
  localparam longint unsigned P_L   = 64'd360 << F;
  localparam longint unsigned OFF_L = P_L * (((64'd1 << 29) + P_L - 64'd1) / P_L);
  localparam longint unsigned M_L   = (64'd1 << UW) / P_L;
  localparam int MW   = $clog2(M_L + 64'd1);
  localparam logic [PW-1:0] P_C      = PW'(P_L);
  localparam logic [PW-1:0] HALF_P_C = PW'(P_L >> 1);
  localparam logic [UW-1:0] OFF_C    = UW'(OFF_L);
  localparam logic [MW-1:0] M_C      = MW'(M_L);
  localparam int NSTG = 106;

  logic en;
  logic [NSTG-1:0] vld_q;
  logic [RAD_W-1:0] radius_q;

  // config register
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= RADIUS_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      radius_q <= earth_radius_i;
    end
  end

  // valid bits travel with the stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NSTG-2:0], in_valid_i};
    end
  end

  // input register
  logic signed [LAT_W-1:0] la_q, lb_q;
  logic signed [LON_W-1:0] loa_q, lob_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      la_q  <= lat_a_i;
      loa_q <= lon_a_i;
      lb_q  <= lat_b_i;
      lob_q <= lon_b_i;
    end
  end

  // per unit angle source: half dlat, half dlon, lat a, lat b
  logic signed [UW-1:0] src [4];
  assign src[0] = UW'(lb_q) - UW'(la_q);
  assign src[1] = UW'(lob_q) - UW'(loa_q);
  assign src[2] = UW'(la_q);
  assign src[3] = UW'(lb_q);

  logic signed [31:0] rx_q [4][CORDIC_STEPS+1];
  logic signed [31:0] ry_q [4][CORDIC_STEPS+1];
  logic signed [31:0] rz_q [4][CORDIC_STEPS+1];
  logic               neg_q [4][CORDIC_STEPS+1];

  for (genvar k = 0; k < 4; k++) begin : g_unit
    localparam int SH = (k < 2) ? F + 3 : F + 2;
    logic [UW-1:0]      u1_q, u2_q;
    logic [MW-1:0]      q_q;
    logic [UW:0]        r_q;
    logic [PW-1:0]      m_q;
    logic [31:0]        th_q;
    logic [UW+MW-1:0]   qprod;
    logic [UW:0]        r_d;
    logic [PW-1:0]      mod_v, m_d;
    logic [PW+26:0]     thp;
    logic signed [32:0] fold;

    // offset to a positive value, then modulo 360 degrees by reciprocal
    assign qprod = (UW+MW)'(u1_q) * (UW+MW)'(M_C);
    assign r_d   = (UW+1)'(u2_q) - (UW+1)'((UW+1)'(q_q) * (UW+1)'(P_C));
    assign mod_v = (r_q >= (UW+1)'(P_C)) ? PW'(r_q - (UW+1)'(P_C)) : PW'(r_q);
    if (k < 2) begin : g_diff
      assign m_d = mod_v;
    end else begin : g_lat
      assign m_d = (mod_v > HALF_P_C) ? P_C - mod_v : mod_v;
    end

    // degrees to q30 radians and fold into the first quadrant
    assign thp  = (PW+27)'(m_q) * (PW+27)'(DEG2RAD_Q32);
    assign fold = 33'(PI_Q30) - 33'(th_q);

    always_ff @(posedge clk_i) begin
      if (en) begin
        u1_q <= unsigned'(src[k] + signed'(OFF_C));
        u2_q <= u1_q;
        q_q  <= qprod[UW +: MW];
        r_q  <= r_d;
        m_q  <= m_d;
        th_q <= thp[SH +: 32];
        rx_q[k][0] <= signed'(CORDIC_GAIN);
        ry_q[k][0] <= '0;
        if (th_q > HALF_PI_Q30) begin
          rz_q[k][0]  <= 32'(fold);
          neg_q[k][0] <= 1'b1;
        end else begin
          rz_q[k][0]  <= signed'(th_q);
          neg_q[k][0] <= 1'b0;
        end
      end
    end

    // rotation cordic, one step per stage
    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_rot
      logic signed [31:0] dx, dy;
      assign dx = ry_q[k][i] >>> i;
      assign dy = rx_q[k][i] >>> i;
      always_ff @(posedge clk_i) begin
        if (en) begin
          neg_q[k][i+1] <= neg_q[k][i];
          if (rz_q[k][i] >= 0) begin
            rx_q[k][i+1] <= rx_q[k][i] - dx;
            ry_q[k][i+1] <= ry_q[k][i] + dy;
            rz_q[k][i+1] <= rz_q[k][i] - signed'(ATAN_Q30[i]);
          end else begin
            rx_q[k][i+1] <= rx_q[k][i] + dx;
            ry_q[k][i+1] <= ry_q[k][i] - dy;
            rz_q[k][i+1] <= rz_q[k][i] + signed'(ATAN_Q30[i]);
          end
        end
      end
    end
  end

  // sin and cos results
  logic signed [31:0] s0, s1, c2, c3;
  assign s0 = ry_q[0][CORDIC_STEPS];
  assign s1 = ry_q[1][CORDIC_STEPS];
  assign c2 = neg_q[2][CORDIC_STEPS] ? -rx_q[2][CORDIC_STEPS] : rx_q[2][CORDIC_STEPS];
  assign c3 = neg_q[3][CORDIC_STEPS] ? -rx_q[3][CORDIC_STEPS] : rx_q[3][CORDIC_STEPS];

  // haversine term a
  logic signed [63:0] p_t1, p_t2, p_cc, p_m2;
  logic signed [31:0] t1_q, t2_q, cc_q, t1b_q, m2_q;
  logic signed [32:0] a_sum;
  logic [30:0]        a_q;
  assign p_t1  = 64'(s0) * 64'(s0);
  assign p_t2  = 64'(s1) * 64'(s1);
  assign p_cc  = 64'(c2) * 64'(c3);
  assign p_m2  = 64'(cc_q) * 64'(t2_q);
  assign a_sum = 33'(t1b_q) + 33'(m2_q);

  always_ff @(posedge clk_i) begin
    if (en) begin
      t1_q  <= p_t1[61:30];
      t2_q  <= p_t2[61:30];
      cc_q  <= p_cc[61:30];
      t1b_q <= t1_q;
      m2_q  <= p_m2[61:30];
      if (a_sum < 0) begin
        a_q <= '0;
      end else if (a_sum > 33'(Q30_ONE)) begin
        a_q <= Q30_ONE;
      end else begin
        a_q <= 31'(a_sum);
      end
    end
  end

  // two square roots, one result bit per stage
  logic [61:0] sv_q [2][CORDIC_STEPS+1];
  logic [61:0] sr_q [2][CORDIC_STEPS+1];
  always_ff @(posedge clk_i) begin
    if (en) begin
      sv_q[0][0] <= {1'b0, a_q, 30'd0};
      sv_q[1][0] <= {1'b0, Q30_ONE - a_q, 30'd0};
      sr_q[0][0] <= '0;
      sr_q[1][0] <= '0;
    end
  end

  for (genvar j = 0; j < 2; j++) begin : g_sqrt
    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
      localparam logic [61:0] BIT = 62'(1) << (60 - 2 * i);
      logic [61:0] trial;
      assign trial = sr_q[j][i] + BIT;
      always_ff @(posedge clk_i) begin
        if (en) begin
          if (sv_q[j][i] >= trial) begin
            sv_q[j][i+1] <= sv_q[j][i] - trial;
            sr_q[j][i+1] <= (sr_q[j][i] >> 1) + BIT;
          end else begin
            sv_q[j][i+1] <= sv_q[j][i];
            sr_q[j][i+1] <= sr_q[j][i] >> 1;
          end
        end
      end
    end
  end

  // vectoring cordic for atan2(sqrt a, sqrt(1-a))
  logic signed [33:0] vx_q [CORDIC_STEPS+1];
  logic signed [33:0] vy_q [CORDIC_STEPS+1];
  logic signed [31:0] vz_q [CORDIC_STEPS+1];
  always_ff @(posedge clk_i) begin
    if (en) begin
      vx_q[0] <= signed'(34'(sr_q[1][CORDIC_STEPS][30:0]));
      vy_q[0] <= signed'(34'(sr_q[0][CORDIC_STEPS][30:0]));
      vz_q[0] <= '0;
    end
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_vec
    logic signed [33:0] dx, dy;
    assign dx = vy_q[i] >>> i;
    assign dy = vx_q[i] >>> i;
    always_ff @(posedge clk_i) begin
      if (en) begin
        if (vy_q[i] > 0) begin
          vx_q[i+1] <= vx_q[i] + dx;
          vy_q[i+1] <= vy_q[i] - dy;
          vz_q[i+1] <= vz_q[i] + signed'(ATAN_Q30[i]);
        end else begin
          vx_q[i+1] <= vx_q[i] - dx;
          vy_q[i+1] <= vy_q[i] + dy;
          vz_q[i+1] <= vz_q[i] - signed'(ATAN_Q30[i]);
        end
      end
    end
  end

  // scale by radius, round and saturate
  logic [30:0] ang;
  logic [50:0] dprod_q;
  logic [51:0] dsum;
  logic [DIST_W-1:0] res_d;
  assign ang  = (vz_q[CORDIC_STEPS] < 0) ? '0 : 31'(vz_q[CORDIC_STEPS]);
  assign dsum = 52'(dprod_q) + (52'(1) << 28);
  assign res_d = (dsum[51:29] > 23'(DIST_MAX)) ? DIST_MAX : dsum[29 +: DIST_W];

  always_ff @(posedge clk_i) begin
    if (en) begin
      dprod_q <= 51'(radius_q) * 51'(ang);
    end
  end

  // output register with skid stage
  logic                out_valid_q, skid_valid_q, out_free;
  logic [DIST_W-1:0]   out_data_q, skid_data_q;
  assign en       = !skid_valid_q;
  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (out_free) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end
    end else if (vld_q[NSTG-1]) begin
      if (out_free) begin
        out_valid_q <= 1'b1;
      end else begin
        skid_valid_q <= 1'b1;
      end
    end else if (out_free) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_free) begin
        out_data_q <= skid_data_q;
      end
    end else if (vld_q[NSTG-1]) begin
      if (out_free) begin
        out_data_q <= res_d;
      end else begin
        skid_data_q <= res_d;
      end
    end
  end

  assign in_stall_o     = skid_valid_q;
  assign out_valid_o    = out_valid_q;
  assign distance_out_o = out_data_q;

endmodule

[tb/great_circle_distance_checker.sv]
// transaction checker for the great circle distance unit
// depends on gcdu_pkg; watches the input, output and config channels
`timescale 1ns / 100ps

module great_circle_distance_checker import gcdu_pkg::*; #(
  parameter int ANGLE_FRAC_BITS = 20
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  input  logic                    in_stall_i,
  input  logic signed [LAT_W-1:0] lat_a_i,
  input  logic signed [LON_W-1:0] lon_a_i,
  input  logic signed [LAT_W-1:0] lat_b_i,
  input  logic signed [LON_W-1:0] lon_b_i,
  input  logic                    out_valid_i,
  input  logic                    out_stall_i,
  input  logic [DIST_W-1:0]       distance_out_i,
  input  logic                    cfg_valid_i,
  input  logic                    cfg_ready_i,
  input  logic [RAD_W-1:0]        earth_radius_i,
  output int                      fail_count_o,
  output int                      pending_o
);

  localparam longint FULL_TURN = longint'(360) << ANGLE_FRAC_BITS;

  logic [RAD_W-1:0]  radius_q;
  logic [DIST_W-1:0] dist_due[$];
  int                fails;

  assign fail_count_o = fails;
  assign pending_o    = dist_due.size();

  // reduce degrees into one turn
  function automatic longint wrap_turn(longint v);
    longint r;
    r = v % FULL_TURN;
    if (r < 0) r += FULL_TURN;
    return r;
  endfunction

  // cordic rotation on an angle in [0, pi]
  function automatic void rotate(input longint theta, output longint s, output longint c);
    longint x, y, z, dx, dy;
    bit     neg;
    x = longint'(CORDIC_GAIN);
    y = 0;
    neg = 1'b0;
    if (theta > longint'(HALF_PI_Q30)) begin
      theta = longint'(PI_Q30) - theta;
      neg = 1'b1;
    end
    z = theta;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(ATAN_Q30[i]);
      end else begin
        x += dx; y -= dy; z += longint'(ATAN_Q30[i]);
      end
    end
    s = y;
    c = neg ? -x : x;
  endfunction

  // cordic vectoring, angle of (x, y)
  function automatic longint vector_angle(longint x, longint y);
    longint z, dx, dy;
    z = 0;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y > 0) begin
        x += dx; y -= dy; z += longint'(ATAN_Q30[i]);
      end else begin
        x -= dx; y += dy; z -= longint'(ATAN_Q30[i]);
      end
    end
    return (z < 0) ? 0 : z;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint half_sin_sq(longint diff);
    longint th, s, c;
    th = (wrap_turn(diff) * longint'(DEG2RAD_Q32)) >>> (ANGLE_FRAC_BITS + 3);
    rotate(th, s, c);
    return (s * s) >>> 30;
  endfunction

  function automatic longint lat_cosine(longint lat);
    longint m, th, s, c;
    m = wrap_turn(lat);
    if (m > FULL_TURN / 2) m = FULL_TURN - m;
    th = (m * longint'(DEG2RAD_Q32)) >>> (ANGLE_FRAC_BITS + 2);
    rotate(th, s, c);
    return c;
  endfunction

  function automatic logic [DIST_W-1:0] haversine(longint la, longint loa, longint lb,
                                                   longint lob, logic [RAD_W-1:0] rad);
    longint          t1, t2, cc, a, ang;
    longint unsigned sa, sb, d;
    t1 = half_sin_sq(lb - la);
    t2 = half_sin_sq(lob - loa);
    cc = (lat_cosine(la) * lat_cosine(lb)) >>> 30;
    a  = t1 + ((cc * t2) >>> 30);
    if (a < 0) a = 0;
    if (a > longint'(Q30_ONE)) a = longint'(Q30_ONE);
    sa  = int_sqrt(longint'(a) << 30);
    sb  = int_sqrt((longint'(Q30_ONE) - a) << 30);
    ang = vector_angle(longint'(sb), longint'(sa));
    d   = (64'd2 * rad * longint'(ang) + (64'd1 << 29)) >> 30;
    if (d > DIST_MAX) d = DIST_MAX;
    return d[DIST_W-1:0];
  endfunction

  // track radius, predict on input, compare on output
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= RADIUS_RESET;
      fails    <= 0;
      dist_due.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) radius_q <= earth_radius_i;
      if (in_valid_i && !in_stall_i)
        dist_due.push_back(haversine(lat_a_i, lon_a_i, lat_b_i, lon_b_i, radius_q));
      if (out_valid_i && !out_stall_i) begin
        if (dist_due.size() == 0) begin
          $display("%0t: unexpected distance %0d, nothing expected", $time, distance_out_i);
          fails <= fails + 1;
        end else if (dist_due[0] !== distance_out_i) begin
          $display("%0t: distance expected %0d actual %0d", $time, dist_due[0],
                   distance_out_i);
          fails <= fails + 1;
          void'(dist_due.pop_front());
        end else begin
          void'(dist_due.pop_front());
        end
      end
    end
  end

endmodule

[tb/great_circle_distance_unit_tb.sv]
// top of the great circle distance unit testbench: clock, stimulus, verdict
// depends on gcdu_pkg, great_circle_distance_unit and great_circle_distance_checker
`timescale 1ns / 100ps

module great_circle_distance_unit_tb import gcdu_pkg::*;;

  localparam longint DEG        = longint'(1) << 20;
  localparam int     DRAIN_WAIT = 120;
  localparam int     CYCLE_CAP  = 400000;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic signed [LAT_W-1:0] lat_a = '0, lat_b = '0;
  logic signed [LON_W-1:0] lon_a = '0, lon_b = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic [DIST_W-1:0]       distance;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [RAD_W-1:0]        cfg_radius = '0;
  int                      fail_count, pending;
  int                      cycles = 0;
  bit                      quiet = 1'b0;

  always #6 clk_i = ~clk_i;

  great_circle_distance_unit dut (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .lat_a_i(lat_a), .lon_a_i(lon_a), .lat_b_i(lat_b), .lon_b_i(lon_b),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .distance_out_o(distance),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready), .earth_radius_i(cfg_radius)
  );

  great_circle_distance_checker chk (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_stall_i(in_stall),
    .lat_a_i(lat_a), .lon_a_i(lon_a), .lat_b_i(lat_b), .lon_b_i(lon_b),
    .out_valid_i(out_valid), .out_stall_i(out_stall), .distance_out_i(distance),
    .cfg_valid_i(cfg_valid), .cfg_ready_i(cfg_ready), .earth_radius_i(cfg_radius),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // run limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // output side backpressure, drawn per result
  initial begin
    int hold;
    forever begin
      @(negedge clk_i);
      hold = quiet ? 0 : $urandom_range(0, 6);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(negedge clk_i);
      end
      out_stall <= 1'b0;
      @(posedge clk_i);
      while (!out_valid) @(posedge clk_i);
    end
  end

  // one position pair transaction; the caller is at a falling edge
  task automatic send_pair(longint la, longint loa, longint lb, longint lob);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid <= 1'b1;
    lat_a <= la[LAT_W-1:0];
    lon_a <= loa[LON_W-1:0];
    lat_b <= lb[LAT_W-1:0];
    lon_b <= lob[LON_W-1:0];
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // write the radius once everything in flight has come out
  task automatic write_radius(logic [RAD_W-1:0] r);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (DRAIN_WAIT) @(negedge clk_i);
    cfg_valid  <= 1'b1;
    cfg_radius <= r;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  function automatic longint rand_field(int w, longint span);
    longint v;
    if ($urandom_range(0, 4) == 0) begin
      v = longint'({$urandom, $urandom});
      v = v <<< (64 - w);
      return v >>> (64 - w);
    end
    return longint'($urandom_range(0, 32'(2 * span))) - span;
  endfunction

  initial begin
    logic [RAD_W-1:0] radii[7];
    longint lat_max, lon_max;
    lat_max = 90 * DEG;
    lon_max = 180 * DEG;
    radii = '{RADIUS_RESET, 20'd1, 20'hFFFFF, 20'd0, 20'd880657, 20'd3440, 20'd0};
    radii[6] = RAD_W'($urandom_range(1, 20'hFFFFF));
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: extremes, wrap, antipodes, out of range latitude
    send_pair(0, 0, 0, 0);
    send_pair(lat_max, 0, -lat_max, 0);
    send_pair(0, -lon_max, 0, lon_max);
    send_pair(0, 0, 0, lon_max);
    send_pair(45 * DEG, 10 * DEG, -45 * DEG, -170 * DEG);
    send_pair(0, -170 * DEG, 0, 170 * DEG);
    send_pair(lat_max, lon_max, lat_max, -lon_max);
    send_pair(-lat_max, -lon_max, lat_max, lon_max);
    send_pair(-(longint'(1) << 27), -(longint'(1) << 28),
              (longint'(1) << 27) - 1, (longint'(1) << 28) - 1);
    send_pair((longint'(1) << 27) - 1, 0, (longint'(1) << 27) - 1, lon_max);
    send_pair(120 * DEG, 0, 120 * DEG, 90 * DEG);
    send_pair(1, 0, 0, 1);
    send_pair(-1, -1, 0, 0);
    send_pair(30 * DEG, 0, 30 * DEG, 1);

    // random pairs under several radius settings
    foreach (radii[p]) begin
      if (p > 0) write_radius(radii[p]);
      for (int n = 0; n < 60; n++) begin
        if (n % 20 == 0) quiet = ($urandom_range(0, 3) == 0);
        send_pair(rand_field(LAT_W, lat_max), rand_field(LON_W, lon_max),
                  rand_field(LAT_W, lat_max), rand_field(LON_W, lon_max));
      end
      quiet = 1'b0;
    end
    in_valid <= 1'b0;

    while (pending != 0) @(negedge clk_i);
    repeat (DRAIN_WAIT) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
